// File: hdl/pfa_pkg.sv
// Shared types, codes and defaults for the page frame allocator.
`default_nettype none

package pfa_pkg;

  localparam int unsigned NUM_FRAMES_DEF  = 8;
  localparam int unsigned MAX_RUNNING_DEF = 64;
  localparam int unsigned MAX_WAITING_DEF = 64;

  localparam int unsigned PID_W   = 16;
  localparam int unsigned PAGES_W = 8;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned EV_W    = 3;

  // results per request word, and the counter that tracks them
  localparam int unsigned NCNT_W  = 4;
  localparam logic [NCNT_W-1:0] RES_CAP = 4'd9;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TERM = 1'b1;

  typedef enum logic [EV_W-1:0] {
    EV_ADMIT    = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_TERM     = 3'd2,
    EV_NOTFOUND = 3'd3,
    EV_FULL     = 3'd4
  } event_e;

  typedef struct packed {
    event_e               code;
    logic [PID_W-1:0]     pid;
    logic [PAGES_W-1:0]   pages;
    logic [MASK_W-1:0]    mask;
  } res_t;

  // command to the frame bitmap unit
  typedef struct packed {
    logic take;      // grab the lowest free frame
    logic put_back;  // return a frame mask
  } frm_cmd_t;

endpackage

`default_nettype wire

// File: hdl/pfa_ram.sv
// Simple dual-port list memory, one write and one registered read.
`default_nettype none

module pfa_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/pfa_frames.sv
// Frame bitmap with free counter and lowest-free-frame finder.
`default_nettype none

module pfa_frames #(
  parameter int unsigned NUM_FRAMES = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  pfa_pkg::frm_cmd_t                cmd_i,
  input  wire [NUM_FRAMES-1:0]             rel_mask_i,
  input  wire [pfa_pkg::PAGES_W-1:0]       rel_pages_i,
  output logic [NUM_FRAMES-1:0]            low_free_o,
  output logic [$clog2(NUM_FRAMES+1)-1:0]  free_cnt_o
);

  import pfa_pkg::*;

  localparam int unsigned FW = $clog2(NUM_FRAMES + 1);

  logic [NUM_FRAMES-1:0] busy_q, busy_d;
  logic [FW-1:0]         free_q, free_d;

  // carry of busy+1 stops at the first zero: isolates the lowest free frame
  assign low_free_o = ~busy_q & (busy_q + NUM_FRAMES'(1));
  assign free_cnt_o = free_q;

  always_comb begin
    busy_d = busy_q;
    free_d = free_q;
    if (cmd_i.take) begin
      busy_d = busy_q | low_free_o;
      free_d = free_q - FW'(1);
    end else if (cmd_i.put_back) begin
      // an admitted entry holds exactly its page count in frames
      busy_d = busy_q & ~rel_mask_i;
      free_d = free_q + FW'(rel_pages_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      free_q <= FW'(NUM_FRAMES);
    end else begin
      busy_q <= busy_d;
      free_q <= free_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/paged_frame_allocator_with_wait_queue.sv
// Top level: request sequencer over the running list, wait list and frame bitmap.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------------------------
//  request   | in        | start_i & ~busy_o    | kind_i, pid_i, pages_i
//  result    | out       | valid_o (1 cycle)    | event_res_o, proc_id_o, page_total_o,
//            |           |                      | frame_mask_o, last_o
//
//  Steps: an admitted add runs the fit check, takes a frame per cycle, writes the list
//  entry and sends the last word; a queued or rejected add runs the fit check and the
//  last word. Terminate searches and moves up running entries, checks each waiter, and
//  admits each waiter that fits, taking its frames and moving the wait entries up; each list memory has one read port.
//  Reset: frames all free, both lists empty; list memories are not cleared.
//  Stalls: none on the result side; start_i is ignored while busy_o is high.
`default_nettype none

module paged_frame_allocator_with_wait_queue #(
  parameter int unsigned NUM_FRAMES  = pfa_pkg::NUM_FRAMES_DEF,
  parameter int unsigned MAX_RUNNING = pfa_pkg::MAX_RUNNING_DEF,
  parameter int unsigned MAX_WAITING = pfa_pkg::MAX_WAITING_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire                          kind_i,
  input  wire [pfa_pkg::PID_W-1:0]     pid_i,
  input  wire [pfa_pkg::PAGES_W-1:0]   pages_i,
  output logic                         valid_o,
  output logic [pfa_pkg::EV_W-1:0]     event_res_o,
  output logic [pfa_pkg::PID_W-1:0]    proc_id_o,
  output logic [pfa_pkg::PAGES_W-1:0]  page_total_o,
  output logic [pfa_pkg::MASK_W-1:0]   frame_mask_o,
  output logic                         last_o
);

  import pfa_pkg::*;

  localparam int unsigned FW     = $clog2(NUM_FRAMES + 1);
  localparam int unsigned RIW    = $clog2(MAX_RUNNING);
  localparam int unsigned RCW    = $clog2(MAX_RUNNING + 1);
  localparam int unsigned WIW    = $clog2(MAX_WAITING);
  localparam int unsigned WCW    = $clog2(MAX_WAITING + 1);
  // running entry: {pid, pages, frames}; waiting entry: {pid, pages}
  localparam int unsigned RUN_W  = PID_W + PAGES_W + NUM_FRAMES;
  localparam int unsigned WAIT_W = PID_W + PAGES_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_ALLOC, S_T_RD, S_T_CMP, S_R_SHIFT, S_R_WR,
    S_W_RD, S_W_CHK, S_W_SHIFT, S_W_WR, S_FLUSH
  } state_e;

  // low eight frames of a full frame mask
  function automatic logic [MASK_W-1:0] mask8(input logic [NUM_FRAMES-1:0] m);
    logic [63:0] ext;
    ext = 64'(m);
    return ext[MASK_W-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [PID_W-1:0]     cur_pid_q, cur_pid_d;
  logic [PAGES_W-1:0]   cur_pages_q, cur_pages_d;
  logic [PAGES_W-1:0]   left_q, left_d;
  logic [NUM_FRAMES-1:0] mask_q, mask_d;
  logic                 from_wait_q, from_wait_d;
  logic [RCW-1:0]       run_cnt_q, run_cnt_d;
  logic [WCW-1:0]       wait_cnt_q, wait_cnt_d;
  logic [RCW-1:0]       idx_q, idx_d;
  logic [WCW-1:0]       widx_q, widx_d;
  logic [WCW-1:0]       jdx_q, jdx_d;
  logic [NCNT_W-1:0]    ncnt_q, ncnt_d;
  res_t                 pend_q, pend_d;
  logic                 pend_vld_q, pend_vld_d;
  res_t                 out_res_q, out_res_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_last_q, out_last_d;

  logic [RCW-1:0]       idx_nx;
  logic [WCW-1:0]       jdx_nx;
  logic                 push;
  res_t                 push_res;

  // list memories
  logic                 run_we;
  logic [RIW-1:0]       run_waddr, run_raddr;
  logic [RUN_W-1:0]     run_wdata, run_rdata;
  logic                 wait_we;
  logic [WIW-1:0]       wait_waddr, wait_raddr;
  logic [WAIT_W-1:0]    wait_wdata, wait_rdata;

  logic [PID_W-1:0]      run_rpid;
  logic [PAGES_W-1:0]    run_rpages;
  logic [NUM_FRAMES-1:0] run_rframes;
  logic [PID_W-1:0]      wait_rpid;
  logic [PAGES_W-1:0]    wait_rpages;

  // frame unit
  frm_cmd_t              fcmd;
  logic [NUM_FRAMES-1:0] low_free;
  logic [FW-1:0]         free_cnt;

  assign {run_rpid, run_rpages, run_rframes} = run_rdata;
  assign {wait_rpid, wait_rpages}            = wait_rdata;

  assign idx_nx = idx_q + RCW'(1);
  assign jdx_nx = jdx_q + WCW'(1);

  pfa_ram #(.WIDTH(RUN_W), .DEPTH(MAX_RUNNING)) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (run_waddr),
    .wdata_i (run_wdata),
    .raddr_i (run_raddr),
    .rdata_o (run_rdata)
  );

  pfa_ram #(.WIDTH(WAIT_W), .DEPTH(MAX_WAITING)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (wait_waddr),
    .wdata_i (wait_wdata),
    .raddr_i (wait_raddr),
    .rdata_o (wait_rdata)
  );

  pfa_frames #(.NUM_FRAMES(NUM_FRAMES)) u_frames (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fcmd),
    .rel_mask_i  (run_rframes),
    .rel_pages_i (run_rpages),
    .low_free_o  (low_free),
    .free_cnt_o  (free_cnt)
  );

  always_comb begin
    state_d     = state_q;
    cur_pid_d   = cur_pid_q;
    cur_pages_d = cur_pages_q;
    left_d      = left_q;
    mask_d      = mask_q;
    from_wait_d = from_wait_q;
    run_cnt_d   = run_cnt_q;
    wait_cnt_d  = wait_cnt_q;
    idx_d       = idx_q;
    widx_d      = widx_q;
    jdx_d       = jdx_q;
    ncnt_d      = ncnt_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    out_res_d   = out_res_q;
    out_vld_d   = 1'b0;
    out_last_d  = out_last_q;

    run_we      = 1'b0;
    run_waddr   = run_cnt_q[RIW-1:0];
    run_wdata   = {cur_pid_q, cur_pages_q, mask_q};
    run_raddr   = idx_q[RIW-1:0];
    wait_we     = 1'b0;
    wait_waddr  = wait_cnt_q[WIW-1:0];
    wait_wdata  = {cur_pid_q, cur_pages_q};
    wait_raddr  = widx_q[WIW-1:0];
    fcmd        = '0;
    push        = 1'b0;
    push_res    = '{code: EV_ADMIT, pid: cur_pid_q, pages: cur_pages_q, mask: '0};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cur_pid_d   = pid_i;
          cur_pages_d = pages_i;
          ncnt_d      = '0;
          idx_d       = '0;
          state_d     = (kind_i == KIND_TERM) ? S_T_RD : S_ADD;
        end
      end

      S_ADD: begin
        if (PAGES_W'(free_cnt) >= cur_pages_q) begin
          if (run_cnt_q < RCW'(MAX_RUNNING)) begin
            left_d      = cur_pages_q;
            mask_d      = '0;
            from_wait_d = 1'b0;
            state_d     = S_ALLOC;
          end else begin
            push          = 1'b1;
            push_res.code = EV_FULL;
            state_d       = S_FLUSH;
          end
        end else if (wait_cnt_q < WCW'(MAX_WAITING)) begin
          wait_we       = 1'b1;
          wait_cnt_d    = wait_cnt_q + WCW'(1);
          push          = 1'b1;
          push_res.code = EV_QUEUED;
          state_d       = S_FLUSH;
        end else begin
          push          = 1'b1;
          push_res.code = EV_FULL;
          state_d       = S_FLUSH;
        end
      end

      // one frame a cycle, lowest free first
      S_ALLOC: begin
        if (left_q != '0) begin
          fcmd.take = 1'b1;
          mask_d    = mask_q | low_free;
          left_d    = left_q - PAGES_W'(1);
        end else begin
          run_we        = 1'b1;
          run_cnt_d     = run_cnt_q + RCW'(1);
          push          = 1'b1;
          push_res.code = EV_ADMIT;
          push_res.mask = mask8(mask_q);
          if (from_wait_q) begin
            jdx_d   = widx_q;
            state_d = S_W_SHIFT;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end

      // linear search for the earliest running entry with this pid
      S_T_RD: begin
        if (idx_q < run_cnt_q) begin
          state_d = S_T_CMP;
        end else begin
          push           = 1'b1;
          push_res.code  = EV_NOTFOUND;
          push_res.pages = '0;
          state_d        = S_FLUSH;
        end
      end

      S_T_CMP: begin
        if (run_rpid == cur_pid_q) begin
          fcmd.put_back  = 1'b1;
          push           = 1'b1;
          push_res.code  = EV_TERM;
          push_res.pages = run_rpages;
          push_res.mask  = mask8(run_rframes);
          state_d        = S_R_SHIFT;
        end else begin
          idx_d   = idx_nx;
          state_d = S_T_RD;
        end
      end

      // close the gap in the running list
      S_R_SHIFT: begin
        if (idx_nx < run_cnt_q) begin
          run_raddr = idx_nx[RIW-1:0];
          state_d   = S_R_WR;
        end else begin
          run_cnt_d = run_cnt_q - RCW'(1);
          widx_d    = '0;
          state_d   = S_W_RD;
        end
      end

      S_R_WR: begin
        run_we    = 1'b1;
        run_waddr = idx_q[RIW-1:0];
        run_wdata = run_rdata;
        idx_d     = idx_nx;
        state_d   = S_R_SHIFT;
      end

      // wait list scan, in order, stopping at the list end or the result cap
      S_W_RD: begin
        if (widx_q < wait_cnt_q && ncnt_q < RES_CAP) begin
          state_d = S_W_CHK;
        end else begin
          state_d = S_FLUSH;
        end
      end

      S_W_CHK: begin
        if (PAGES_W'(free_cnt) >= wait_rpages && run_cnt_q < RCW'(MAX_RUNNING)) begin
          cur_pid_d   = wait_rpid;
          cur_pages_d = wait_rpages;
          left_d      = wait_rpages;
          mask_d      = '0;
          from_wait_d = 1'b1;
          state_d     = S_ALLOC;
        end else begin
          widx_d  = widx_q + WCW'(1);
          state_d = S_W_RD;
        end
      end

      // drop the admitted waiter; scan resumes at the same slot
      S_W_SHIFT: begin
        if (jdx_nx < wait_cnt_q) begin
          wait_raddr = jdx_nx[WIW-1:0];
          state_d    = S_W_WR;
        end else begin
          wait_cnt_d = wait_cnt_q - WCW'(1);
          state_d    = S_W_RD;
        end
      end

      S_W_WR: begin
        wait_we    = 1'b1;
        wait_waddr = jdx_q[WIW-1:0];
        wait_wdata = wait_rdata;
        jdx_d      = jdx_nx;
        state_d    = S_W_SHIFT;
      end

      // the held word is the final one
      S_FLUSH: begin
        out_vld_d  = 1'b1;
        out_res_d  = pend_q;
        out_last_d = 1'b1;
        pend_vld_d = 1'b0;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a new word pushes the held one out with last clear
    if (push) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_res_d  = pend_q;
        out_last_d = 1'b0;
      end
      pend_d     = push_res;
      pend_vld_d = 1'b1;
      ncnt_d     = ncnt_q + NCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_cnt_q   <= '0;
      wait_cnt_q  <= '0;
      ncnt_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      from_wait_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_cnt_q   <= run_cnt_d;
      wait_cnt_q  <= wait_cnt_d;
      ncnt_q      <= ncnt_d;
      pend_vld_q  <= pend_vld_d;
      out_vld_q   <= out_vld_d;
      from_wait_q <= from_wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pid_q   <= cur_pid_d;
    cur_pages_q <= cur_pages_d;
    left_q      <= left_d;
    mask_q      <= mask_d;
    idx_q       <= idx_d;
    widx_q      <= widx_d;
    jdx_q       <= jdx_d;
    pend_q      <= pend_d;
    out_res_q   <= out_res_d;
    out_last_q  <= out_last_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign valid_o      = out_vld_q;
  assign event_res_o  = out_res_q.code;
  assign proc_id_o    = out_res_q.pid;
  assign page_total_o = out_res_q.pages;
  assign frame_mask_o = out_res_q.mask;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  a_run_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_cnt_q <= RCW'(MAX_RUNNING))
    else $error("running list count beyond depth");

  a_wait_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_cnt_q <= WCW'(MAX_WAITING))
    else $error("wait list count beyond depth");

  a_take_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC && left_q != '0) |-> (low_free != '0 && free_cnt != '0))
    else $error("frame taken with no free frame");

  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q <= RES_CAP)
    else $error("too many results for one request");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  a_mid_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy_o)
    else $error("non-final result word after request finished");
`endif

endmodule

`default_nettype wire
